// ----- src/lat_pkg.sv -----
// ----------------------------------------------------------------------------
// lat_pkg: shared definitions for the toroidal life automaton
// Operation codes, configuration register indexes, field widths, default
// grid dimensions, the sequencer state type and the row cell control bundle.
// ----------------------------------------------------------------------------
package lat_pkg;

  // Default grid dimensions.
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 128;

  // Field widths of the input, output and configuration ports.
  localparam int OP_W       = 2;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_GEN   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

  // Configuration reset values.
  localparam logic [ROWS_CFG_W-1:0] ROWS_USED_RST = 6'd25;
  localparam logic [COLS_CFG_W-1:0] COLS_USED_RST = 8'd80;

  typedef enum logic {
    ST_IDLE,
    ST_GEN
  } lat_state_t;

  // Per-row control from the sequencer.
  typedef struct packed {
    logic shift;
    logic wr;
    logic val;
  } cell_ctl_t;

endpackage

// ----- src/lat_row_cell.sv -----
// ----------------------------------------------------------------------------
// lat_row_cell: one grid row of the automaton
// Holds one row of cells. During a generation it takes the row handed up by
// its neighbor in the chain; otherwise it can have a single cell written.
// ----------------------------------------------------------------------------
module lat_row_cell #(
  parameter int MAX_COLS = lat_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lat_pkg::cell_ctl_t          ctl,
  input  logic [$clog2(MAX_COLS)-1:0] wr_col,
  input  logic [MAX_COLS-1:0]         shift_in,
  output logic [MAX_COLS-1:0]         row
);
  import lat_pkg::*;

  logic [MAX_COLS-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (ctl.shift) begin
      row_r <= shift_in;
    end else if (ctl.wr) begin
      row_r[wr_col] <= ctl.val;
    end
  end

  assign row = row_r;

endmodule

// ----- src/lat_next_row.sv -----
// ----------------------------------------------------------------------------
// lat_next_row: next-generation rule for one row
// Counts the eight neighbors of each column in use from the rows above, at and
// below, wrapping at the last column in use, and applies the rules; others keep mid.
// ----------------------------------------------------------------------------
module lat_next_row #(
  parameter int MAX_COLS = lat_pkg::MAX_COLS_DEF
) (
  input  logic [MAX_COLS-1:0]           up,
  input  logic [MAX_COLS-1:0]           mid,
  input  logic [MAX_COLS-1:0]           down,
  input  logic [$clog2(MAX_COLS+1)-1:0] ncols,
  output logic [MAX_COLS-1:0]           fresh
);
  import lat_pkg::*;

  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  logic [CIDX_W-1:0] last_col;
  logic              up_last;
  logic              mid_last;
  logic              down_last;

  assign last_col  = CIDX_W'(ncols - CCNT_W'(1));
  assign up_last   = up[last_col];
  assign mid_last  = mid[last_col];
  assign down_last = down[last_col];

  always_comb begin
    logic       ul, ml, dl, ur, mr, dr;
    logic [3:0] n;
    fresh = mid;
    for (int c = 0; c < MAX_COLS; c++) begin
      // Column zero wraps to the last column in use, and the last one to zero.
      if (c == 0) begin
        ul = up_last;
        ml = mid_last;
        dl = down_last;
      end else begin
        ul = up[(c + MAX_COLS - 1) % MAX_COLS];
        ml = mid[(c + MAX_COLS - 1) % MAX_COLS];
        dl = down[(c + MAX_COLS - 1) % MAX_COLS];
      end
      if (32'(c) + 32'd1 == 32'(ncols)) begin
        ur = up[0];
        mr = mid[0];
        dr = down[0];
      end else begin
        ur = up[(c + 1) % MAX_COLS];
        mr = mid[(c + 1) % MAX_COLS];
        dr = down[(c + 1) % MAX_COLS];
      end
      n = 4'(ul) + 4'(up[c]) + 4'(ur) + 4'(ml) + 4'(mr)
        + 4'(dl) + 4'(down[c]) + 4'(dr);
      if (32'(c) < 32'(ncols)) begin
        if (mid[c]) begin
          fresh[c] = (n == 4'd2) || (n == 4'd3);
        end else begin
          fresh[c] = (n == 4'd3);
        end
      end
    end
  end

endmodule

// ----- src/life_automaton_torus.sv -----
// ----------------------------------------------------------------------------
// life_automaton_torus: Conway's Game of Life on a wrapping grid
// A chain of row cells holds the grid; a generation rotates the rows in use
// through the chain while the next-row logic computes each new row.
// ----------------------------------------------------------------------------
// Every accepted transaction gives exactly one result, shown on out_valid and
// out_cell_alive for one cycle; the receiver cannot stall it. A cell write or
// read gives its result in the next cycle, and busy stays low so a new
// transaction can follow at once. A generation keeps busy high while the
// rows in use (the effective rows_used, at most MAX_ROWS) pass through the
// chain, which shifts one row through the next-row logic per cycle; the
// result strobe comes right after the last row is shifted. A generation
// with zero rows or columns in use finishes like a read or write.
// Configuration writes must be made while no transaction is in progress.
module life_automaton_torus #(
  parameter int MAX_ROWS = lat_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lat_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lat_pkg::OP_W-1:0]      in_op,
  input  logic [lat_pkg::ROW_W-1:0]     in_row,
  input  logic [lat_pkg::COL_W-1:0]     in_col,
  input  logic                          in_alive,
  output logic                          out_valid,
  output logic                          out_cell_alive,
  input  logic                          cfg_we,
  input  logic [lat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lat_pkg::CFG_W-1:0]     cfg_wdata
);
  import lat_pkg::*;

  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  logic [ROWS_CFG_W-1:0] rows_used_r;
  logic [COLS_CFG_W-1:0] cols_used_r;
  lat_state_t            state_r, state_nxt;
  logic [RIDX_W-1:0]     k_r, k_nxt;
  logic [MAX_COLS-1:0]   first_r, first_nxt;
  logic [MAX_COLS-1:0]   prior_r, prior_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_cell_r, out_cell_nxt;

  logic [MAX_COLS-1:0] rows [MAX_ROWS];
  logic [RCNT_W-1:0]   eff_rows;
  logic [CCNT_W-1:0]   eff_cols;
  logic [RIDX_W-1:0]   last_row;
  logic [RIDX_W-1:0]   sel_idx;
  logic [MAX_COLS-1:0] sel_row;
  logic [MAX_COLS-1:0] up_row;
  logic [MAX_COLS-1:0] down_row;
  logic [MAX_COLS-1:0] fresh_row;
  logic                accept;
  logic                in_grid;
  logic                gen_go;
  logic                gen_last;

  // Size in use, limited to the grid.
  always_comb begin
    if (32'(rows_used_r) > 32'(MAX_ROWS)) begin
      eff_rows = RCNT_W'(MAX_ROWS);
    end else begin
      eff_rows = RCNT_W'(rows_used_r);
    end
    if (32'(cols_used_r) > 32'(MAX_COLS)) begin
      eff_cols = CCNT_W'(MAX_COLS);
    end else begin
      eff_cols = CCNT_W'(cols_used_r);
    end
  end

  assign last_row = RIDX_W'(eff_rows - RCNT_W'(1));
  assign accept   = start && !busy;
  assign in_grid  = (32'(in_row) < 32'(eff_rows)) && (32'(in_col) < 32'(eff_cols));
  assign gen_go   = accept && (in_op == OP_GEN) && (eff_rows != '0) && (eff_cols != '0);
  assign gen_last = (state_r == ST_GEN) && (k_r == last_row);

  // One row mux serves reads when idle and the wrap row during a generation.
  assign sel_idx = (state_r == ST_GEN) ? last_row : RIDX_W'(in_row);
  assign sel_row = rows[sel_idx];

  // Row zero of the chain is always the row being computed; rows already
  // replaced are stood in for by the copies of the old first and prior rows.
  assign up_row   = (k_r == '0) ? sel_row : prior_r;
  assign down_row = (k_r == last_row) ? first_r : rows[1];

  lat_next_row #(
    .MAX_COLS(MAX_COLS)
  ) u_next_row (
    .up    (up_row),
    .mid   (rows[0]),
    .down  (down_row),
    .ncols (eff_cols),
    .fresh (fresh_row)
  );

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
    cell_ctl_t           ctl;
    logic [MAX_COLS-1:0] shift_in;

    assign ctl.shift = busy && (32'(i) < 32'(eff_rows));
    assign ctl.wr    = accept && (in_op == OP_WRITE) && in_grid
                       && (RIDX_W'(in_row) == RIDX_W'(i));
    assign ctl.val   = in_alive;
    assign shift_in  = (RIDX_W'(i) == last_row) ? fresh_row : rows[(i + 1) % MAX_ROWS];

    lat_row_cell #(
      .MAX_COLS(MAX_COLS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_col   (CIDX_W'(in_col)),
      .shift_in (shift_in),
      .row      (rows[i])
    );
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (gen_go) begin
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        k_nxt = k_r + RIDX_W'(1);
        if (k_r == last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        k_nxt     = '0;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_GEN:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign first_nxt     = gen_go ? rows[0] : first_r;
  assign prior_nxt     = busy ? rows[0] : prior_r;
  assign out_valid_nxt = (accept && !gen_go) || gen_last;
  assign out_cell_nxt  = accept && (in_op == OP_READ) && in_grid && sel_row[CIDX_W'(in_col)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      rows_used_r <= ROWS_USED_RST;
      cols_used_r <= COLS_USED_RST;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS_USED: rows_used_r <= cfg_wdata[ROWS_CFG_W-1:0];
          CFG_COLS_USED: cols_used_r <= cfg_wdata[COLS_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r    <= '0;
      prior_r    <= '0;
      out_cell_r <= 1'b0;
    end else begin
      first_r    <= first_nxt;
      prior_r    <= prior_nxt;
      out_cell_r <= out_cell_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_r;

endmodule
